>>> design/glzw_pkg.sv
// ----------------------------------------------------------------------------
// glzw_pkg: shared types and constants for the GIF LZW decoder
// Holds the table geometry defaults, the register map, the action codes and the
// bit positions of the result tuser flags.
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int TABLE_SIZE_DEF    = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_MIN_CODE = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_HEIGHT   = 2'd2;

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_PULL  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    localparam int MIN_CODE_RESET = 8;

    // result tuser flag positions
    localparam int TU_PIXEL_VALID = 0;
    localparam int TU_BYTE_TAKEN  = 1;
    localparam int TU_NEED_DATA   = 2;
    localparam int TU_FINISHED    = 3;
    localparam int TU_EARLY_STOP  = 4;

    typedef logic [7:0] byte_t;

endpackage

>>> design/glzw_ram.sv
// ----------------------------------------------------------------------------
// glzw_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/gif_lzw_decoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder: GIF-style LZW decoder, variable code width up to 12 bits
// Byte push, pixel pull and image start through one stream word each.
// ----------------------------------------------------------------------------
// One word is handled at a time. A push or a start goes from the accept
// straight to the result word; a pull that finds a pixel already on the
// expansion stack pops it. A pull that has to fetch a new code walks its
// prefix chain through the dictionary RAMs, one link per walk and read
// step, then adds the table entry, pops and returns the result; the
// remaining pixels of the string come out one per pull. A clear code ahead
// of a literal adds one more decode step. A stalled result word holds off
// the next word. The registered dictionary read sets the pace of the chain
// walk. The dictionary needs no clearing pass: only entries written since
// the last clear code are ever read.
module gif_lzw_decoder
    import glzw_pkg::*;
#(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // [7:0] data_byte
    input  logic [7:0]            s_tuser,  // [1:0] action, rest zero
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // [7:0] pixel_index
    output logic [7:0]            m_tuser   // [0] pixel_valid [1] byte_taken
                                            // [2] need_data [3] finished
                                            // [4] early_stop, rest zero
);

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int SDW = AW + 1;
    localparam int CW  = MAX_CODE_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // config registers
    logic [3:0]  min_code_reg;
    logic [15:0] img_w_reg;
    logic [15:0] img_h_reg;
    logic [31:0] total_pix;

    // decoder state
    logic [2:0]     state_reg, state_next;
    logic [23:0]    buf_reg, buf_next;
    logic [4:0]     fill_reg, fill_next;
    logic [3:0]     cw_reg, cw_next;
    logic [SDW-1:0] nf_reg, nf_next;
    logic [SDW-1:0] depth_reg, depth_next;
    logic [CW-1:0]  prev_code_reg, prev_code_next;
    byte_t          prev_first_reg, prev_first_next;
    logic [31:0]    pix_cnt_reg, pix_cnt_next;
    logic           after_clear_reg, after_clear_next;
    logic           stopped_reg, stopped_next;
    logic [CW-1:0]  walk_reg, walk_next;
    logic [CW-1:0]  code_reg, code_next;
    logic           kwk_reg, kwk_next;
    byte_t          first_reg, first_next;
    byte_t          pix_reg, pix_next;
    logic           valid_reg, valid_next;
    logic           taken_reg, taken_next;
    logic           need_reg, need_next;

    logic           m_tvalid_reg;
    byte_t          m_data_reg;
    logic [4:0]     m_flags_reg;

    // memories
    logic           push_en;
    byte_t          push_data;
    logic [AW-1:0]  stk_raddr;
    byte_t          stk_rdata;
    logic           dict_we;
    logic [AW-1:0]  dict_waddr;
    logic [CW-1:0]  pre_rdata;
    byte_t          suf_rdata;

    logic [3:0]     eff_min;
    logic [8:0]     clr;
    logic [CW-1:0]  code_mask;
    logic [CW-1:0]  code_now;
    logic           accept;
    logic           cfg_wr;
    logic [SDW-1:0] nf_inc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_MIN_CODE: prdata = {28'd0, min_code_reg};
            REG_WIDTH:    prdata = {16'd0, img_w_reg};
            REG_HEIGHT:   prdata = {16'd0, img_h_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_code_reg <= 4'(MIN_CODE_RESET);
            img_w_reg    <= '0;
            img_h_reg    <= '0;
        end else begin
            if (cfg_wr) begin
                priority case (paddr[3:2])
                    REG_MIN_CODE: min_code_reg <= pwdata[3:0];
                    REG_WIDTH:    img_w_reg    <= pwdata[15:0];
                    REG_HEIGHT:   img_h_reg    <= pwdata[15:0];
                    default:      ;
                endcase
            end
        end
    end

    assign total_pix = img_w_reg * img_h_reg;

    always_comb begin
        if (min_code_reg < 4'd2) begin
            eff_min = 4'd2;
        end else if (min_code_reg > 4'd8) begin
            eff_min = 4'd8;
        end else begin
            eff_min = min_code_reg;
        end
    end

    assign clr       = 9'd1 << eff_min;
    assign code_mask = (CW'(1) << cw_reg) - CW'(1);
    assign code_now  = CW'(buf_reg) & code_mask;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign nf_inc    = nf_reg + SDW'(1);

    assign stk_raddr  = AW'(depth_reg - SDW'(1));
    assign dict_waddr = AW'(nf_reg);

    always_comb begin
        state_next       = state_reg;
        buf_next         = buf_reg;
        fill_next        = fill_reg;
        cw_next          = cw_reg;
        nf_next          = nf_reg;
        depth_next       = depth_reg;
        prev_code_next   = prev_code_reg;
        prev_first_next  = prev_first_reg;
        pix_cnt_next     = pix_cnt_reg;
        after_clear_next = after_clear_reg;
        stopped_next     = stopped_reg;
        walk_next        = walk_reg;
        code_next        = code_reg;
        kwk_next         = kwk_reg;
        first_next       = first_reg;
        pix_next         = pix_reg;
        valid_next       = valid_reg;
        taken_next       = taken_reg;
        need_next        = need_reg;
        push_en          = 1'b0;
        push_data        = prev_first_reg;
        dict_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pix_next   = '0;
                    valid_next = 1'b0;
                    taken_next = 1'b0;
                    need_next  = 1'b0;
                    state_next = ST_DONE;
                    priority case (s_tuser[1:0])
                        ACT_PUSH: begin
                            if (fill_reg <= 5'd16) begin
                                buf_next   = buf_reg | (24'(s_tdata) << fill_reg);
                                fill_next  = fill_reg + 5'd8;
                                taken_next = 1'b1;
                            end
                        end
                        ACT_PULL: begin
                            if (!stopped_reg && pix_cnt_reg < total_pix) begin
                                state_next = ST_CHECK;
                            end
                        end
                        ACT_START: begin
                            buf_next         = '0;
                            fill_next        = '0;
                            depth_next       = '0;
                            prev_code_next   = '0;
                            prev_first_next  = '0;
                            pix_cnt_next     = '0;
                            stopped_next     = 1'b0;
                            cw_next          = eff_min + 4'd1;
                            nf_next          = SDW'(clr) + SDW'(2);
                            after_clear_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            ST_CHECK: begin
                if (stopped_reg) begin
                    state_next = ST_DONE;
                end else if (depth_reg != '0) begin
                    state_next = ST_POP;
                end else if (fill_reg < 5'(cw_reg)) begin
                    need_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    buf_next  = buf_reg >> cw_reg;
                    fill_next = fill_reg - 5'(cw_reg);
                    code_next = code_now;
                    if (32'(code_now) == 32'(clr)) begin
                        cw_next          = eff_min + 4'd1;
                        nf_next          = SDW'(clr) + SDW'(2);
                        after_clear_next = 1'b1;
                    end else if (32'(code_now) == 32'(clr) + 32'd1) begin
                        stopped_next = 1'b1;
                    end else if (after_clear_reg) begin
                        // literal after a clear, masked into the root range
                        push_en          = 1'b1;
                        push_data        = byte_t'(code_now & (CW'(clr) - CW'(1)));
                        prev_code_next   = code_now & (CW'(clr) - CW'(1));
                        prev_first_next  = push_data;
                        after_clear_next = 1'b0;
                    end else if (32'(code_now) < 32'(nf_reg)) begin
                        kwk_next   = 1'b0;
                        walk_next  = code_now;
                        state_next = ST_WALK;
                    end else begin
                        // code not yet in table: previous string plus its first
                        push_en    = 1'b1;
                        push_data  = prev_first_reg;
                        kwk_next   = 1'b1;
                        walk_next  = prev_code_reg;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_POP: begin
                depth_next   = depth_reg - SDW'(1);
                pix_cnt_next = pix_cnt_reg + 32'd1;
                pix_next     = stk_rdata;
                valid_next   = 1'b1;
                state_next   = ST_DONE;
            end

            ST_WALK: begin
                if (32'(walk_reg) >= 32'(clr) && 32'(walk_reg) < TABLE_SIZE) begin
                    state_next = ST_READ;
                end else begin
                    push_en    = 1'b1;
                    push_data  = byte_t'(walk_reg);
                    first_next = byte_t'(walk_reg);
                    state_next = ST_ADD;
                end
            end

            ST_READ: begin
                push_en    = 1'b1;
                push_data  = suf_rdata;
                walk_next  = pre_rdata;
                state_next = ST_WALK;
            end

            ST_ADD: begin
                if (32'(nf_reg) < TABLE_SIZE) begin
                    dict_we = 1'b1;
                    nf_next = nf_inc;
                    if (32'(nf_inc) == (32'd1 << cw_reg) && 32'(cw_reg) < CW) begin
                        cw_next = cw_reg + 4'd1;
                    end
                    if (kwk_reg) begin
                        prev_code_next = CW'(nf_reg);
                    end
                end
                if (!kwk_reg) begin
                    prev_code_next  = code_reg;
                    prev_first_next = first_reg;
                end
                state_next = ST_CHECK;
            end

            ST_DONE: begin
                state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase

        if (push_en && 32'(depth_reg) < TABLE_SIZE) begin
            depth_next = depth_reg + SDW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            buf_reg         <= '0;
            fill_reg        <= '0;
            cw_reg          <= 4'(MIN_CODE_RESET + 1);
            nf_reg          <= SDW'((1 << MIN_CODE_RESET) + 2);
            depth_reg       <= '0;
            prev_code_reg   <= '0;
            prev_first_reg  <= '0;
            pix_cnt_reg     <= '0;
            after_clear_reg <= 1'b1;
            stopped_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            buf_reg         <= buf_next;
            fill_reg        <= fill_next;
            cw_reg          <= cw_next;
            nf_reg          <= nf_next;
            depth_reg       <= depth_next;
            prev_code_reg   <= prev_code_next;
            prev_first_reg  <= prev_first_next;
            pix_cnt_reg     <= pix_cnt_next;
            after_clear_reg <= after_clear_next;
            stopped_reg     <= stopped_next;
            if (state_reg == ST_DONE) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg  <= walk_next;
        code_reg  <= code_next;
        kwk_reg   <= kwk_next;
        first_reg <= first_next;
        pix_reg   <= pix_next;
        valid_reg <= valid_next;
        taken_reg <= taken_next;
        need_reg  <= need_next;
        if (state_reg == ST_DONE) begin
            m_data_reg <= pix_reg;
            m_flags_reg[TU_PIXEL_VALID] <= valid_reg;
            m_flags_reg[TU_BYTE_TAKEN]  <= taken_reg;
            m_flags_reg[TU_NEED_DATA]   <= need_reg;
            m_flags_reg[TU_FINISHED]    <= stopped_reg || pix_cnt_reg >= total_pix;
            m_flags_reg[TU_EARLY_STOP]  <= stopped_reg && pix_cnt_reg < total_pix;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {3'd0, m_flags_reg};

    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_stack (
        .aclk  (aclk),
        .we    (push_en && 32'(depth_reg) < TABLE_SIZE),
        .waddr (AW'(depth_reg)),
        .wdata (push_data),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    glzw_ram #(.WIDTH(CW), .DEPTH(TABLE_SIZE)) u_prefix (
        .aclk  (aclk),
        .we    (dict_we),
        .waddr (dict_waddr),
        .wdata (prev_code_reg),
        .raddr (AW'(walk_reg)),
        .rdata (pre_rdata)
    );

    glzw_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_suffix (
        .aclk  (aclk),
        .we    (dict_we),
        .waddr (dict_waddr),
        .wdata (kwk_reg ? prev_first_reg : first_reg),
        .raddr (AW'(walk_reg)),
        .rdata (suf_rdata)
    );

endmodule

>>> design/glzw_checker.sv
// ----------------------------------------------------------------------------
// glzw_checker: port-level checks for the GIF LZW decoder
// Watches the stream ports and the result flags over time.
// ----------------------------------------------------------------------------
module glzw_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [7:0] m_tuser
);
    import glzw_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TU_PIXEL_VALID] |->
            !m_tuser[TU_BYTE_TAKEN] && !m_tuser[TU_NEED_DATA])
        else $error("pixel flagged together with push or need_data");

    a_early: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TU_EARLY_STOP] |-> m_tuser[TU_FINISHED])
        else $error("early stop without finished");

    a_nopix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TU_PIXEL_VALID] |-> m_tdata == 8'd0)
        else $error("pixel index nonzero without a pixel");

endmodule

bind gif_lzw_decoder glzw_checker u_glzw_checker (.*);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the GIF LZW decoder
// Builds LZW code streams with random content, packs them LSB-first into
// bytes and feeds push, pull and invalid-action words in random bursts. Every result word is
// compared against a bit-true decoder model that runs in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import glzw_pkg::*;

    localparam int TBL = 4096;
    localparam int MAXW = 12;
    localparam int IDLE_LIMIT = 60000;
    localparam logic [1:0] ACT_BAD = 2'd3;

    typedef struct packed {
        logic [7:0] pix;
        logic       valid;
        logic       taken;
        logic       need;
        logic       fin;
        logic       early;
    } pix_result_t;

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  data;
        bit          typed;
        pix_result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [7:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [7:0]  m_tuser;

    always #2 aclk = ~aclk;

    gif_lzw_decoder dut (.*);

    // ---------------- decoder model ----------------
    logic [11:0] dict_prefix [TBL];
    logic [7:0]  dict_suffix [TBL];
    logic [7:0]  pix_stack   [TBL];
    int unsigned stk_depth, bit_acc, bit_cnt, code_w, free_code;
    int unsigned prev_code, prev_first, pix_count;
    bit          fresh_clear, halted;
    int unsigned reg_min, reg_w, reg_h;

    pix_result_t pending_pix[$];
    int          err_cnt = 0;

    function automatic int unsigned min_size();
        return (reg_min < 2) ? 2 : (reg_min > 8) ? 8 : reg_min;
    endfunction

    function automatic int unsigned pix_total();
        return reg_w * reg_h;
    endfunction

    task automatic dict_reset();
        int unsigned clr;
        clr = 1 << min_size();
        for (int i = 0; i < clr; i++) begin
            dict_suffix[i] = i[7:0];
            dict_prefix[i] = '0;
        end
        code_w = min_size() + 1;
        free_code = clr + 2;
        fresh_clear = 1;
    endtask

    task automatic image_reset();
        for (int i = 0; i < TBL; i++) begin
            dict_prefix[i] = '0;
            dict_suffix[i] = '0;
            pix_stack[i] = '0;
        end
        stk_depth = 0; bit_acc = 0; bit_cnt = 0;
        prev_code = 0; prev_first = 0; pix_count = 0;
        halted = 0;
        dict_reset();
    endtask

    task automatic stack_put(int unsigned v);
        if (stk_depth < TBL) begin
            pix_stack[stk_depth] = v[7:0];
            stk_depth++;
        end
    endtask

    task automatic unwind(int unsigned c, int unsigned clr, output int unsigned first);
        int unsigned steps;
        steps = 0;
        while (c >= clr && c < TBL && steps < TBL) begin
            stack_put(dict_suffix[c]);
            c = dict_prefix[c];
            steps++;
        end
        first = c & 8'hFF;
        stack_put(first);
    endtask

    task automatic dict_add(int unsigned pre, int unsigned first);
        if (free_code < TBL) begin
            dict_prefix[free_code] = pre[11:0];
            dict_suffix[free_code] = first[7:0];
            free_code++;
            if (free_code == (1 << code_w) && code_w < MAXW) code_w++;
        end
    endtask

    task automatic code_apply(int unsigned code);
        int unsigned clr, first, slot;
        bit room;
        clr = 1 << min_size();
        if (code == clr) begin
            dict_reset();
        end else if (code == clr + 1) begin
            halted = 1;
        end else if (fresh_clear) begin
            first = code & (clr - 1);
            stack_put(first);
            prev_code = first;
            prev_first = first;
            fresh_clear = 0;
        end else if (code < free_code) begin
            unwind(code, clr, first);
            dict_add(prev_code, first);
            prev_code = code;
            prev_first = first;
        end else begin
            // code not yet in the table
            slot = free_code;
            room = free_code < TBL;
            stack_put(prev_first);
            unwind(prev_code, clr, first);
            dict_add(prev_code, prev_first);
            if (room) prev_code = slot;
        end
    endtask

    task automatic decode_word(logic [1:0] act, logic [7:0] data, output pix_result_t r);
        int unsigned code;
        r = '0;
        if (act == ACT_PUSH) begin
            if (bit_cnt <= 16) begin
                bit_acc = (bit_acc | (int'(data) << bit_cnt)) & 24'hFFFFFF;
                bit_cnt += 8;
                r.taken = 1;
            end
        end else if (act == ACT_PULL) begin
            if (!halted && pix_count < pix_total()) begin
                while (stk_depth == 0 && !halted) begin
                    if (bit_cnt < code_w) begin
                        r.need = 1;
                        break;
                    end
                    code = bit_acc & ((1 << code_w) - 1);
                    bit_acc >>= code_w;
                    bit_cnt -= code_w;
                    code_apply(code);
                end
                if (stk_depth > 0 && !halted) begin
                    stk_depth--;
                    r.pix = pix_stack[stk_depth];
                    pix_count++;
                    r.valid = 1;
                end
            end
        end else if (act == ACT_START) begin
            image_reset();
        end
        r.fin = halted || pix_count >= pix_total();
        r.early = halted && pix_count < pix_total();
    endtask

    // ---------------- checking ----------------
    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        pix_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pix.size() == 0) begin
                report("unexpected word", m_tuser, 0);
            end else begin
                e = pending_pix.pop_front();
                if (m_tdata != e.pix) report("pixel_index", m_tdata, e.pix);
                if (m_tuser[TU_PIXEL_VALID] != e.valid)
                    report("pixel_valid", m_tuser[TU_PIXEL_VALID], e.valid);
                if (m_tuser[TU_BYTE_TAKEN] != e.taken)
                    report("byte_taken", m_tuser[TU_BYTE_TAKEN], e.taken);
                if (m_tuser[TU_NEED_DATA] != e.need)
                    report("need_data", m_tuser[TU_NEED_DATA], e.need);
                if (m_tuser[TU_FINISHED] != e.fin)
                    report("finished", m_tuser[TU_FINISHED], e.fin);
                if (m_tuser[TU_EARLY_STOP] != e.early)
                    report("early_stop", m_tuser[TU_EARLY_STOP], e.early);
                if (m_tuser[7:5] != 3'b0) report("tuser spare", m_tuser[7:5], 0);
            end
        end
    end

    // receiver stall pattern, changes character with rcyc[10:9]
    int unsigned rcyc = 0;
    always @(posedge aclk) begin
        rcyc <= rcyc + 1;
        case (rcyc[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= (rcyc[2:0] != 3'd0);
            2'd2: m_tready <= ((rcyc % 5) < 2);
            default: m_tready <= (rcyc[4:0] < 5'd12);
        endcase
    end

    // watchdog on cycles with no word moving
    int unsigned quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    int burst_left = 0;

    task automatic send_word(logic [1:0] act, logic [7:0] data, output pix_result_t r);
        int gap;
        decode_word(act, data, r);
        pending_pix.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {6'b0, act};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MIN_CODE: reg_min = val & 32'hF;
            REG_WIDTH:    reg_w = val & 32'hFFFF;
            default:      reg_h = val & 32'hFFFF;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // one image: random code stream, pushes and pulls interleaved
    task automatic run_image(int unsigned msz, int unsigned w, int unsigned h, int ncodes);
        byte_t       stream[$];
        int unsigned m, clr, gw, gfree, code, acc, nacc;
        bit          lit;
        int          iters;
        pix_result_t r;
        drain();
        reg_write(REG_MIN_CODE, msz);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        send_word(ACT_START, 8'($urandom_range(0, 255)), r);
        m = min_size();
        clr = 1 << m;
        gw = m + 1; gfree = clr + 2; lit = 1;
        acc = 0; nacc = 0;
        for (int i = 0; i < ncodes; i++) begin
            if ((i == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 60) == 0) begin
                code = clr;
                gw = m + 1; gfree = clr + 2; lit = 1;
            end else if (i == ncodes - 1 && $urandom_range(0, 2) != 0) begin
                code = clr + 1;
            end else begin
                if (lit || $urandom_range(0, 30) == 0) code = $urandom_range(0, (1 << gw) - 1);
                else code = $urandom_range(0, gfree);
                if (code == clr || code == clr + 1) code = $urandom_range(0, clr - 1);
                if (lit) lit = 0;
                else if (gfree < TBL) begin
                    gfree++;
                    if (gfree == (1 << gw) && gw < MAXW) gw++;
                end
            end
            acc |= code << nacc;
            nacc += gw;
            while (nacc >= 8) begin
                stream.push_back(acc[7:0]);
                acc >>= 8;
                nacc -= 8;
            end
        end
        if (nacc > 0) stream.push_back(acc[7:0]);
        iters = 0;
        r = '0;
        // stop once the image is done, or once the stream is used up and a pull needs data
        while (iters < 600 && !(r.fin || (stream.size() == 0 && r.need))) begin
            iters++;
            if ($urandom_range(0, 49) == 0) begin
                send_word(ACT_BAD, 8'($urandom_range(0, 255)), r);
            end else if (stream.size() != 0 &&
                         ((bit_cnt <= 16 && $urandom_range(0, 2) != 0) ||
                          $urandom_range(0, 19) == 0)) begin
                send_word(ACT_PUSH, stream[0], r);
                if (r.taken) void'(stream.pop_front());
            end else begin
                send_word(ACT_PULL, 8'($urandom_range(0, 255)), r);
            end
        end
        repeat ($urandom_range(0, 3)) send_word(ACT_PULL, 8'h00, r);
    endtask

    dir_row_t dir_rows[$];
    pix_result_t tmp;

    initial begin
        int total;
        // reset state: 0 x 0 image, so every word reports finished
        dir_rows = '{
            '{ACT_PUSH,  8'hFF, 1, '{8'h00, 0, 1, 0, 1, 0}},
            '{ACT_PUSH,  8'h00, 1, '{8'h00, 0, 1, 0, 1, 0}},
            '{ACT_PUSH,  8'hAA, 1, '{8'h00, 0, 1, 0, 1, 0}},
            '{ACT_PUSH,  8'h55, 1, '{8'h00, 0, 0, 0, 1, 0}},
            '{ACT_PULL,  8'hFF, 1, '{8'h00, 0, 0, 0, 1, 0}},
            '{ACT_BAD,   8'hFF, 1, '{8'h00, 0, 0, 0, 1, 0}},
            '{ACT_START, 8'h00, 1, '{8'h00, 0, 0, 0, 1, 0}},
            '{ACT_PULL,  8'h00, 0, '{8'h00, 0, 0, 0, 0, 0}}
        };
        reg_min = MIN_CODE_RESET; reg_w = 0; reg_h = 0;
        image_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].act, dir_rows[i].data, tmp);
            if (dir_rows[i].typed) pending_pix[pending_pix.size() - 1] = dir_rows[i].res;
        end
        // extremes of the registers, including out of range code sizes
        run_image(8, 4, 3, 12);
        run_image(2, 1, 1, 6);
        run_image(0, 5, 5, 20);
        run_image(15, 65535, 65535, 30);
        run_image(9, 0, 7, 6);
        run_image(1, 3, 65535, 25);
        total = 0;
        while (total < 1400) begin
            total += 80;
            run_image($urandom_range(0, 15), $urandom_range(1, 14),
                      $urandom_range(1, 14), $urandom_range(8, 45));
        end
        drain();
        repeat (50) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> gif_lzw_decoder.f
design/glzw_pkg.sv
design/glzw_ram.sv
design/gif_lzw_decoder.sv
design/glzw_checker.sv
bench/testbench.sv
